### design/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg: shared types and constants of the infix to postfix converter
// Operator codes, result status codes, character classes, controller command
// and datapath status structs, and small lookup functions.
// ----------------------------------------------------------------------------
package itp_pkg;

   localparam int STACK_DEPTH_DEF = 32;

   localparam logic [2:0] CODE_OPEN = 3'd0;
   localparam logic [2:0] CODE_ADD  = 3'd1;
   localparam logic [2:0] CODE_SUB  = 3'd2;
   localparam logic [2:0] CODE_MUL  = 3'd3;
   localparam logic [2:0] CODE_DIV  = 3'd4;
   localparam logic [2:0] CODE_MOD  = 3'd5;

   localparam logic [7:0] CH_OPEN  = 8'h28;
   localparam logic [7:0] CH_CLOSE = 8'h29;
   localparam logic [7:0] CH_MUL   = 8'h2A;
   localparam logic [7:0] CH_ADD   = 8'h2B;
   localparam logic [7:0] CH_SUB   = 8'h2D;
   localparam logic [7:0] CH_DIV   = 8'h2F;
   localparam logic [7:0] CH_MOD   = 8'h25;

   typedef enum logic [2:0] {
      ST_CHAR     = 3'd0,
      ST_DONE     = 3'd1,
      ST_CLOSE    = 3'd2,
      ST_ILLEGAL  = 3'd3,
      ST_OVERFLOW = 3'd4,
      ST_OPEN     = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      CLS_OPEN  = 3'd0,
      CLS_CLOSE = 3'd1,
      CLS_ALNUM = 3'd2,
      CLS_OP    = 3'd3,
      CLS_BAD   = 3'd4
   } class_type;

   typedef enum logic [2:0] {
      ACT_NONE = 3'd0,
      ACT_POP  = 3'd1,
      ACT_PUSH = 3'd2,
      ACT_DROP = 3'd3,
      ACT_EMIT = 3'd4,
      ACT_FAIL = 3'd5,
      ACT_DONE = 3'd6
   } action_type;

   typedef struct packed {
      action_type act;
      status_type status;
      logic       last;
   } cmd_type;

   typedef struct packed {
      logic      is_end;
      class_type cls;
      logic      err;
      logic      empty;
      logic      full;
      logic      top_open;
      logic      pop_op;
      logic      below_pop_op;
      logic      below_open;
      logic      out_free;
   } stat_type;

   function automatic class_type classify(input logic [7:0] ch);
      class_type c;
      if (ch == CH_OPEN) begin
         c = CLS_OPEN;
      end else if (ch == CH_CLOSE) begin
         c = CLS_CLOSE;
      end else if ((ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h41 && ch <= 8'h5A) ||
                   (ch >= 8'h61 && ch <= 8'h7A)) begin
         c = CLS_ALNUM;
      end else if (ch == CH_ADD || ch == CH_SUB || ch == CH_MUL || ch == CH_DIV ||
                   ch == CH_MOD) begin
         c = CLS_OP;
      end else begin
         c = CLS_BAD;
      end
      return c;
   endfunction

   function automatic logic [2:0] op_code(input logic [7:0] ch);
      logic [2:0] c;
      case (ch)
         CH_ADD:  c = CODE_ADD;
         CH_SUB:  c = CODE_SUB;
         CH_MUL:  c = CODE_MUL;
         CH_DIV:  c = CODE_DIV;
         CH_MOD:  c = CODE_MOD;
         default: c = CODE_OPEN;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] code_char(input logic [2:0] code);
      logic [7:0] c;
      case (code)
         CODE_OPEN: c = CH_OPEN;
         CODE_ADD:  c = CH_ADD;
         CODE_SUB:  c = CH_SUB;
         CODE_MUL:  c = CH_MUL;
         CODE_DIV:  c = CH_DIV;
         CODE_MOD:  c = CH_MOD;
         default:   c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic prio(input logic [2:0] code);
      return (code >= CODE_MUL);
   endfunction

endpackage

### design/infix_to_postfix_converter_unit.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit: shunting-yard infix to postfix converter
// Request channel req_*: one ASCII symbol per request, req_tuser flags the
// end of an expression. Result channel rsp_*: postfix characters, error and
// done codes in rsp_tuser, rsp_tlast on the final result of each request.
// A request is taken only while the unit is idle. Each request passes
// through the evaluate step, and every operator popped from the stack adds
// a wait step for the registered stack memory read of the new top.
// Results go through an output register; while the receiver stalls, the
// unit holds in its evaluate step until the register frees, and requests
// that give no result still complete.
// Synchronous reset empties the stack, clears the error flag and the
// output valid flag; stack memory contents need no clearing.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_unit #(
   parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] symbol
   input  logic [0:0] req_tuser,   // [0] end_of_expr
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic [2:0] rsp_tuser,   // [2:0] status
   output logic       rsp_tlast
);

   itp_pkg::cmd_type  cmd;
   itp_pkg::stat_type stat;
   logic              load;

   assign load = req_tvalid && req_tready;

   itp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .stat      (stat),
      .req_ready (req_tready),
      .cmd       (cmd)
   );

   itp_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .req_symbol (req_tdata),
      .req_end    (req_tuser[0]),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### design/itp_ctrl.sv
// ----------------------------------------------------------------------------
// itp_ctrl: sequencing controller of the infix to postfix converter
// Takes one request, evaluates it against the stack top each pass and issues
// pop, push, drop, emit, error and done commands to the datapath.
// ----------------------------------------------------------------------------
module itp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  itp_pkg::stat_type stat,
   output logic             req_ready,
   output itp_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EVAL = 3'b010,
      S_WAIT = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in   = state_ff;
      cmd.act    = itp_pkg::ACT_NONE;
      cmd.status = itp_pkg::ST_CHAR;
      cmd.last   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (load) begin
               state_in = S_EVAL;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_WAIT: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (stat.is_end) begin
               if (!stat.err && !stat.empty && !stat.top_open) begin
                  if (stat.out_free) begin
                     cmd.act  = itp_pkg::ACT_POP;
                     state_in = S_WAIT;
                  end
               end else if (!stat.err && !stat.empty) begin
                  if (stat.out_free) begin
                     cmd.act    = itp_pkg::ACT_FAIL;
                     cmd.status = itp_pkg::ST_OPEN;
                     state_in   = S_WAIT;
                  end
               end else if (stat.out_free) begin
                  cmd.act    = itp_pkg::ACT_DONE;
                  cmd.status = itp_pkg::ST_DONE;
                  cmd.last   = 1'b1;
                  state_in   = S_IDLE;
               end
            end else if (stat.err) begin
               state_in = S_IDLE;
            end else begin
               case (stat.cls)
                  itp_pkg::CLS_OPEN: begin
                     if (!stat.full) begin
                        cmd.act  = itp_pkg::ACT_PUSH;
                        state_in = S_IDLE;
                     end else if (stat.out_free) begin
                        cmd.act    = itp_pkg::ACT_FAIL;
                        cmd.status = itp_pkg::ST_OVERFLOW;
                        cmd.last   = 1'b1;
                        state_in   = S_IDLE;
                     end
                  end
                  itp_pkg::CLS_CLOSE: begin
                     if (!stat.empty && !stat.top_open) begin
                        if (stat.out_free) begin
                           cmd.act  = itp_pkg::ACT_POP;
                           cmd.last = stat.below_open;
                           state_in = S_WAIT;
                        end
                     end else if (!stat.empty) begin
                        cmd.act  = itp_pkg::ACT_DROP;
                        state_in = S_IDLE;
                     end else if (stat.out_free) begin
                        cmd.act    = itp_pkg::ACT_FAIL;
                        cmd.status = itp_pkg::ST_CLOSE;
                        cmd.last   = 1'b1;
                        state_in   = S_IDLE;
                     end
                  end
                  itp_pkg::CLS_ALNUM: begin
                     if (stat.out_free) begin
                        cmd.act  = itp_pkg::ACT_EMIT;
                        cmd.last = 1'b1;
                        state_in = S_IDLE;
                     end
                  end
                  itp_pkg::CLS_OP: begin
                     if (stat.pop_op) begin
                        if (stat.out_free) begin
                           cmd.act  = itp_pkg::ACT_POP;
                           cmd.last = !stat.below_pop_op;
                           state_in = S_WAIT;
                        end
                     end else if (!stat.full) begin
                        cmd.act  = itp_pkg::ACT_PUSH;
                        state_in = S_IDLE;
                     end else if (stat.out_free) begin
                        cmd.act    = itp_pkg::ACT_FAIL;
                        cmd.status = itp_pkg::ST_OVERFLOW;
                        cmd.last   = 1'b1;
                        state_in   = S_IDLE;
                     end
                  end
                  default: begin
                     if (stat.out_free) begin
                        cmd.act    = itp_pkg::ACT_FAIL;
                        cmd.status = itp_pkg::ST_ILLEGAL;
                        cmd.last   = 1'b1;
                        state_in   = S_IDLE;
                     end
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

### design/itp_datapath.sv
// ----------------------------------------------------------------------------
// itp_datapath: operator stack, request holding and result register
// Stack memory with two registered read ports (top and the entry below),
// entry count, error flag, symbol decode and the output register.
// ----------------------------------------------------------------------------
module itp_datapath #(
   parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  logic [7:0]        req_symbol,
   input  logic              req_end,
   input  itp_pkg::cmd_type   cmd,
   output itp_pkg::stat_type  stat,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic [2:0]        rsp_tuser,
   output logic              rsp_tlast
);

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   logic [2:0]    mem [STACK_DEPTH];
   logic [2:0]    rd1_ff, rd2_ff;
   logic [CW-1:0] count_ff, count_in;
   logic          err_ff, err_in;
   logic [7:0]    sym_ff;
   logic          end_ff;
   logic          rsp_valid_ff;
   logic [7:0]    rsp_data_ff;
   logic [2:0]    rsp_user_ff;
   logic          rsp_last_ff;
   logic [CW-1:0] cnt_m1, cnt_m2;
   logic [2:0]    sym_code, push_code;
   logic          emit;
   logic [7:0]    emit_char;
   itp_pkg::class_type cls;

   assign cnt_m1    = count_ff - CW'(1);
   assign cnt_m2    = count_ff - CW'(2);
   assign cls       = itp_pkg::classify(sym_ff);
   assign sym_code  = itp_pkg::op_code(sym_ff);
   assign push_code = (cls == itp_pkg::CLS_OPEN) ? itp_pkg::CODE_OPEN : sym_code;

   always_ff @(posedge clock) begin
      if (cmd.act == itp_pkg::ACT_PUSH) begin
         mem[count_ff[AW-1:0]] <= push_code;
      end
      rd1_ff <= mem[cnt_m1[AW-1:0]];
      rd2_ff <= mem[cnt_m2[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sym_ff <= req_symbol;
         end_ff <= req_end;
      end
   end

   always_comb begin
      count_in = count_ff;
      err_in   = err_ff;
      case (cmd.act)
         itp_pkg::ACT_PUSH: count_in = count_ff + CW'(1);
         itp_pkg::ACT_POP,
         itp_pkg::ACT_DROP: count_in = cnt_m1;
         itp_pkg::ACT_FAIL: begin
            count_in = '0;
            err_in   = 1'b1;
         end
         itp_pkg::ACT_DONE: begin
            count_in = '0;
            err_in   = 1'b0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         err_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         err_ff   <= err_in;
      end
   end

   assign stat.is_end       = end_ff;
   assign stat.cls          = cls;
   assign stat.err          = err_ff;
   assign stat.empty        = (count_ff == '0);
   assign stat.full         = (count_ff >= CW'(STACK_DEPTH));
   assign stat.top_open     = (rd1_ff == itp_pkg::CODE_OPEN);
   assign stat.pop_op       = (count_ff != '0) && (rd1_ff != itp_pkg::CODE_OPEN) &&
                              (itp_pkg::prio(rd1_ff) >= itp_pkg::prio(sym_code));
   assign stat.below_pop_op = (count_ff >= CW'(2)) && (rd2_ff != itp_pkg::CODE_OPEN) &&
                              (itp_pkg::prio(rd2_ff) >= itp_pkg::prio(sym_code));
   assign stat.below_open   = (count_ff >= CW'(2)) && (rd2_ff == itp_pkg::CODE_OPEN);
   assign stat.out_free     = !rsp_valid_ff || rsp_tready;

   assign emit = (cmd.act == itp_pkg::ACT_POP) || (cmd.act == itp_pkg::ACT_EMIT) ||
                 (cmd.act == itp_pkg::ACT_FAIL) || (cmd.act == itp_pkg::ACT_DONE);

   always_comb begin
      case (cmd.act)
         itp_pkg::ACT_POP:  emit_char = itp_pkg::code_char(rd1_ff);
         itp_pkg::ACT_EMIT: emit_char = sym_ff;
         default:           emit_char = 8'h00;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= emit_char;
         rsp_user_ff <= cmd.status;
         rsp_last_ff <= cmd.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_err_empty: assert property (@(posedge clock) disable iff (reset)
      err_ff |-> (count_ff == '0))
      else $error("stack not empty while in error");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff == itp_pkg::ST_DONE) |-> rsp_last_ff)
      else $error("done marker without last");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !emit)
      else $error("result overwritten while stalled");

endmodule

### tb/sv/infix_to_postfix_converter_unit_checker.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit_checker: postfix output scoreboard
// Watches the request and result channels of the converter. Every accepted
// request runs through a shunting-yard predictor with its own operator
// stack and error flag. The postfix characters and status codes it predicts
// are queued in order, and each accepted result is compared field by field
// with the oldest entry.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_unit_checker #(
   parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] symbol
   input  logic [0:0] req_tuser,   // [0] end_of_expr
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,   // [7:0] out_char
   input  logic [2:0] rsp_tuser,   // [2:0] status
   input  logic       rsp_tlast,
   output int         mismatch_count,
   output int         postfix_pending,
   output int         symbols_processed,
   output int         results_checked,
   output int         codes_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0]          ch;
      itp_pkg::status_type st;
      logic                last;
   } postfix_out_type;

   postfix_out_type postfix_q [$];
   postfix_out_type step_q [$];

   logic [2:0] op_stack_m [STACK_DEPTH];
   int         stack_depth;
   bit         in_error;
   int         fails;
   int         processed;
   int         checked;
   int         codes;

   function automatic bit is_operand_char(input logic [7:0] s);
      return (s >= "0" && s <= "9") || (s >= "A" && s <= "Z") || (s >= "a" && s <= "z");
   endfunction

   function automatic bit is_operator_char(input logic [7:0] s);
      return s == itp_pkg::CH_ADD || s == itp_pkg::CH_SUB || s == itp_pkg::CH_MUL ||
             s == itp_pkg::CH_DIV || s == itp_pkg::CH_MOD;
   endfunction

   function automatic logic [2:0] operator_of(input logic [7:0] s);
      logic [2:0] c;
      case (s)
         itp_pkg::CH_ADD: c = itp_pkg::CODE_ADD;
         itp_pkg::CH_SUB: c = itp_pkg::CODE_SUB;
         itp_pkg::CH_MUL: c = itp_pkg::CODE_MUL;
         itp_pkg::CH_DIV: c = itp_pkg::CODE_DIV;
         default:         c = itp_pkg::CODE_MOD;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] glyph_of(input logic [2:0] code);
      logic [7:0] g;
      case (code)
         itp_pkg::CODE_ADD: g = itp_pkg::CH_ADD;
         itp_pkg::CODE_SUB: g = itp_pkg::CH_SUB;
         itp_pkg::CODE_MUL: g = itp_pkg::CH_MUL;
         itp_pkg::CODE_DIV: g = itp_pkg::CH_DIV;
         itp_pkg::CODE_MOD: g = itp_pkg::CH_MOD;
         default:           g = itp_pkg::CH_OPEN;
      endcase
      return g;
   endfunction

   function automatic bit binds_tight(input logic [2:0] code);
      return code == itp_pkg::CODE_MUL || code == itp_pkg::CODE_DIV ||
             code == itp_pkg::CODE_MOD;
   endfunction

   task automatic put(input logic [7:0] c, input itp_pkg::status_type s);
      postfix_out_type r;
      r.ch = c;
      r.st = s;
      r.last = 1'b0;
      step_q.push_back(r);
   endtask

   task automatic pop_out();
      stack_depth--;
      put(glyph_of(op_stack_m[stack_depth]), itp_pkg::ST_CHAR);
   endtask

   task automatic trip(input itp_pkg::status_type s);
      stack_depth = 0;
      in_error = 1'b1;
      put(8'h00, s);
   endtask

   task automatic push_code(input logic [2:0] code);
      if (stack_depth >= STACK_DEPTH) begin
         trip(itp_pkg::ST_OVERFLOW);
      end else begin
         op_stack_m[stack_depth] = code;
         stack_depth++;
      end
   endtask

   task automatic predict_postfix(input logic [7:0] sym, input logic eoe);
      logic [2:0]      code;
      postfix_out_type tail;
      step_q.delete();
      if (eoe || !in_error) processed++;
      if (eoe) begin
         if (!in_error) begin
            while (stack_depth > 0 && op_stack_m[stack_depth-1] != itp_pkg::CODE_OPEN)
               pop_out();
            if (stack_depth > 0) put(8'h00, itp_pkg::ST_OPEN);
         end
         stack_depth = 0;
         in_error = 1'b0;
         put(8'h00, itp_pkg::ST_DONE);
      end else if (in_error) begin
         // dropped until the end of the expression
      end else if (sym == itp_pkg::CH_OPEN) begin
         push_code(itp_pkg::CODE_OPEN);
      end else if (sym == itp_pkg::CH_CLOSE) begin
         while (stack_depth > 0 && op_stack_m[stack_depth-1] != itp_pkg::CODE_OPEN)
            pop_out();
         if (stack_depth == 0) trip(itp_pkg::ST_CLOSE);
         else stack_depth--;
      end else if (is_operand_char(sym)) begin
         put(sym, itp_pkg::ST_CHAR);
      end else if (is_operator_char(sym)) begin
         code = operator_of(sym);
         while (stack_depth > 0 && op_stack_m[stack_depth-1] != itp_pkg::CODE_OPEN &&
                binds_tight(op_stack_m[stack_depth-1]) >= binds_tight(code)) pop_out();
         push_code(code);
      end else begin
         trip(itp_pkg::ST_ILLEGAL);
      end
      if (step_q.size() > 0) begin
         tail = step_q.pop_back();
         tail.last = 1'b1;
         step_q.push_back(tail);
      end
      foreach (step_q[i]) postfix_q.push_back(step_q[i]);
   endtask

   always @(posedge clock) begin
      postfix_out_type want;
      if (reset) begin
         stack_depth = 0;
         in_error = 1'b0;
         postfix_q.delete();
      end else begin
         if (req_tvalid && req_tready) predict_postfix(req_tdata, req_tuser[0]);
         if (rsp_tvalid && rsp_tready) begin
            if (postfix_q.size() == 0) begin
               $error("result with nothing pending: out_char %h status %0d last %b",
                      rsp_tdata, rsp_tuser, rsp_tlast);
               fails++;
            end else begin
               want = postfix_q.pop_front();
               checked++;
               if (want.st != itp_pkg::ST_CHAR) codes++;
               if (rsp_tdata !== want.ch) begin
                  $error("out_char: expected %h, got %h", want.ch, rsp_tdata);
                  fails++;
               end
               if (rsp_tuser !== want.st) begin
                  $error("status: expected %0d, got %0d", want.st, rsp_tuser);
                  fails++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last: expected %b, got %b", want.last, rsp_tlast);
                  fails++;
               end
            end
         end
      end
      mismatch_count    <= fails;
      postfix_pending   <= postfix_q.size();
      symbols_processed <= processed;
      results_checked   <= checked;
      codes_checked     <= codes;
   end

endmodule

### tb/sv/infix_to_postfix_converter_unit_test.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit_test: converter testbench top
// Drives short directed expressions covering every operator, all operand
// ranges and all error codes but overflow, then random well-formed and
// broken expressions, deep nesting up to stack overflow, raw bytes. Both
// channels idle and stall at random; the checker predicts and compares.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = itp_pkg::STACK_DEPTH_DEF;
   localparam int CYCLE_LIMIT = 400_000;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [7:0] symbol
   logic [0:0] req_tuser  = 1'b0;    // [0] end_of_expr
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [7:0] out_char
   logic [2:0] rsp_tuser;            // [2:0] status
   logic       rsp_tlast;

   int mismatch_count;
   int postfix_pending;
   int symbols_processed;
   int results_checked;
   int codes_checked;
   int cycle_count;
   int request_count;
   int expression_count;
   bit req_rush;
   bit rsp_rush;

   infix_to_postfix_converter_unit #(.STACK_DEPTH(DEPTH)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   infix_to_postfix_converter_unit_checker #(.STACK_DEPTH(DEPTH)) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .req_tuser         (req_tuser),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .rsp_tuser         (rsp_tuser),
      .rsp_tlast         (rsp_tlast),
      .mismatch_count    (mismatch_count),
      .postfix_pending   (postfix_pending),
      .symbols_processed (symbols_processed),
      .results_checked   (results_checked),
      .codes_checked     (codes_checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[infix_to_postfix_converter_unit] ERROR");
         $finish;
      end
   end

   // result sink: random stall before each result, with stall-free stretches
   initial begin : sink
      int w;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 24) == 0) rsp_rush = !rsp_rush;
         w = rsp_rush ? 0 : $urandom_range(0, 11);
         if (w > 0) begin
            rsp_tready <= 1'b0;
            repeat (w) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid === 1'b1 && rsp_tready));
      end
   end

   task automatic send_symbol(input logic [7:0] sym, input logic eoe);
      int gap;
      gap = req_rush ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sym;
      req_tuser  <= eoe;
      do @(posedge clock); while (req_tready !== 1'b1);
      request_count++;
      if (eoe) expression_count++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_symbol(s[i], 1'b0);
   endtask

   task automatic finish_expression();
      send_symbol(8'($urandom_range(0, 255)), 1'b1);
      req_rush = ($urandom_range(0, 3) == 0);
   endtask

   function automatic logic [7:0] random_operand();
      logic [7:0] c;
      case ($urandom_range(0, 2))
         0:       c = 8'($urandom_range("0", "9"));
         1:       c = 8'($urandom_range("A", "Z"));
         default: c = 8'($urandom_range("a", "z"));
      endcase
      return c;
   endfunction

   function automatic logic [7:0] random_operator();
      logic [7:0] c;
      case ($urandom_range(0, 4))
         0:       c = itp_pkg::CH_ADD;
         1:       c = itp_pkg::CH_SUB;
         2:       c = itp_pkg::CH_MUL;
         3:       c = itp_pkg::CH_DIV;
         default: c = itp_pkg::CH_MOD;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] random_illegal();
      logic [7:0] c;
      case ($urandom_range(0, 2))
         0:       c = 8'($urandom_range(8'h00, 8'h24));
         1:       c = 8'($urandom_range(8'h7B, 8'hFF));
         default: c = 8'h20;
      endcase
      return c;
   endfunction

   task automatic send_expression();
      int terms;
      int opens;
      terms = $urandom_range(1, 8);
      opens = 0;
      for (int k = 0; k < terms; k++) begin
         while (opens < 6 && $urandom_range(0, 3) == 0) begin
            send_symbol(itp_pkg::CH_OPEN, 1'b0);
            opens++;
         end
         send_symbol(random_operand(), 1'b0);
         while (opens > 0 && $urandom_range(0, 2) == 0) begin
            send_symbol(itp_pkg::CH_CLOSE, 1'b0);
            opens--;
         end
         if (k < terms - 1) send_symbol(random_operator(), 1'b0);
      end
      case ($urandom_range(0, 9))
         0: ;  // leave opens behind
         1: begin
            repeat (opens + 1) send_symbol(itp_pkg::CH_CLOSE, 1'b0);
            send_symbol(random_operand(), 1'b0);
         end
         2: begin
            send_symbol(random_illegal(), 1'b0);
            send_symbol(random_operand(), 1'b0);
         end
         default: repeat (opens) send_symbol(itp_pkg::CH_CLOSE, 1'b0);
      endcase
      finish_expression();
   endtask

   // nest until the stack sits just below, at or just past its depth
   task automatic send_deep();
      int target;
      int pushed;
      target = $urandom_range(DEPTH - 1, DEPTH + 1);
      pushed = 0;
      while (pushed < target) begin
         send_symbol(itp_pkg::CH_OPEN, 1'b0);
         pushed++;
         if (pushed < target && $urandom_range(0, 1) == 0) begin
            send_symbol(random_operand(), 1'b0);
            send_symbol(random_operator(), 1'b0);
            pushed++;
         end
      end
      send_symbol(random_operand(), 1'b0);
      if ($urandom_range(0, 1) == 0) send_symbol(random_operator(), 1'b0);
      finish_expression();
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 6))
         send_symbol(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      finish_expression();
   endtask

   initial begin : stimulus
      int pick;
      while (reset) @(posedge clock);

      send_text("A+b*9-z/0%Z");
      send_symbol(8'hFF, 1'b1);
      send_text("(a-b");
      send_symbol(8'h00, 1'b1);
      send_text("a+b)x");
      send_symbol(8'h80, 1'b1);
      send_symbol(8'h00, 1'b0);
      send_symbol(8'h7F, 1'b1);

      while (request_count < 250) begin
         pick = $urandom_range(0, 19);
         if (pick < 13) send_expression();
         else if (pick < 15) send_deep();
         else send_noise();
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (postfix_pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("sent %0d requests in %0d expressions, %0d of them processed",
               request_count, expression_count, symbols_processed);
      $display("compared %0d results, %0d of them done or error codes",
               results_checked, codes_checked);
      if (mismatch_count == 0 && postfix_pending == 0) begin
         $display("[infix_to_postfix_converter_unit] OK");
      end else begin
         $display("[infix_to_postfix_converter_unit] ERROR");
      end
      $finish;
   end

endmodule
